// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the divider RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

// Implication after a fixed number of cycles.
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed: ante -> ##dly cons");

`endif

// ===== rtl/idmu_pkg.sv =====
// Types and constants for the pipelined integer divide/modulo unit.
// Depends on nothing; used by every idmu module.
package idmu_pkg;

    // Operand width and pipeline latency (pre stage, one stage per bit, post stage)
    localparam int DATA_W = 32;
    localparam int LAT    = DATA_W + 2;

    // Operation codes on the op port
    localparam logic [1:0] OP_SQUOT  = 2'd0;
    localparam logic [1:0] OP_SREM   = 2'd1;
    localparam logic [1:0] OP_UREM   = 2'd2;
    // No meaning; answered with zero
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // What the post stage delivers
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_QUOT = 2'd1,
        KIND_REM  = 2'd2
    } kind_t;

    // Control that travels with each item
    typedef struct packed {
        kind_t kind;
        logic  neg;
    } ctl_t;

    // Datapath word of one divide step
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dvs;
    } stage_t;

endpackage

// ===== rtl/idmu_pre.sv =====
// Operand conditioning stage: magnitudes, sign of the result, special cases.
// Depends on idmu_pkg.
module idmu_pre (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  op,
    input  logic [idmu_pkg::DATA_W-1:0] dividend,
    input  logic [idmu_pkg::DATA_W-1:0] divisor,
    output logic                        valid_reg,
    output idmu_pkg::ctl_t              ctl_reg,
    output idmu_pkg::stage_t            data_reg
);

    localparam int W = idmu_pkg::DATA_W;

    idmu_pkg::ctl_t   ctl_next;
    idmu_pkg::stage_t data_next;
    logic             a_neg;
    logic             b_neg;
    logic [W-1:0]     a_mag;
    logic [W-1:0]     b_mag;

    // Two's complement magnitudes
    assign a_neg = dividend[W-1];
    assign b_neg = divisor[W-1];
    assign a_mag = a_neg ? (~dividend + {{(W-1){1'b0}}, 1'b1}) : dividend;
    assign b_mag = b_neg ? (~divisor + {{(W-1){1'b0}}, 1'b1}) : divisor;

    // Decode operation; zero divisor and the unused code give zero
    always_comb
    begin
        ctl_next.kind  = idmu_pkg::KIND_ZERO;
        ctl_next.neg   = 1'b0;
        data_next.rem  = '0;
        data_next.quo  = a_mag;
        data_next.dvs  = b_mag;
        case (op)
            idmu_pkg::OP_SQUOT:
            begin
                ctl_next.kind = idmu_pkg::KIND_QUOT;
                ctl_next.neg  = a_neg ^ b_neg;
            end
            idmu_pkg::OP_SREM:
            begin
                ctl_next.kind = idmu_pkg::KIND_REM;
                ctl_next.neg  = a_neg;
            end
            idmu_pkg::OP_UREM:
            begin
                ctl_next.kind = idmu_pkg::KIND_REM;
                data_next.quo = dividend;
                data_next.dvs = divisor;
            end
            default:
            begin
                ctl_next.kind = idmu_pkg::KIND_ZERO;
            end
        endcase
        if (divisor == '0)
        begin
            ctl_next.kind = idmu_pkg::KIND_ZERO;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        ctl_reg  <= ctl_next;
        data_reg <= data_next;
    end

endmodule

// ===== rtl/idmu_stage.sv =====
// One restoring divide step: shift in a dividend bit, trial subtract, keep a quotient bit.
// Depends on idmu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module idmu_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  idmu_pkg::ctl_t   ctl_in,
    input  idmu_pkg::stage_t data_in,
    output logic             valid_reg,
    output idmu_pkg::ctl_t   ctl_reg,
    output idmu_pkg::stage_t data_reg
);

    localparam int W = idmu_pkg::DATA_W;

    idmu_pkg::stage_t data_next;
    logic [W:0]       shifted;
    logic [W-1:0]     diff;
    logic             ge;

    // Trial subtract of the divisor from the shifted partial remainder
    // (when it fits, the difference is below the divisor, so W bits hold it)
    assign shifted = {data_in.rem, data_in.quo[W-1]};
    assign diff    = shifted[W-1:0] - data_in.dvs;
    assign ge      = (shifted >= {1'b0, data_in.dvs});

    always_comb
    begin
        data_next.dvs = data_in.dvs;
        data_next.quo = {data_in.quo[W-2:0], ge};
        data_next.rem = ge ? diff : shifted[W-1:0];
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        ctl_reg  <= ctl_in;
        data_reg <= data_next;
    end

    // Partial remainder stays below a nonzero divisor
    `ASSERT_IMPLIES(a_rem_below_dvs, clk, rst_n, valid_reg && (data_reg.dvs != '0), data_reg.rem < data_reg.dvs)
    // Valid bit moves one stage per cycle
    `ASSERT_NEXT(a_valid_moves, clk, rst_n, valid_in, valid_reg)

endmodule

// ===== rtl/idmu_post.sv =====
// Result stage: picks quotient, remainder or zero, restores the sign, drives the strobe.
// Depends on idmu_pkg.
module idmu_post (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    input  idmu_pkg::ctl_t              ctl_in,
    input  idmu_pkg::stage_t            data_in,
    output logic                        done_reg,
    output logic [idmu_pkg::DATA_W-1:0] result_reg
);

    localparam int W = idmu_pkg::DATA_W;

    logic [W-1:0] mag;
    logic [W-1:0] result_next;

    // Select and sign restore
    always_comb
    begin
        mag = data_in.quo;
        case (ctl_in.kind)
            idmu_pkg::KIND_QUOT: mag = data_in.quo;
            idmu_pkg::KIND_REM:  mag = data_in.rem;
            default:             mag = '0;
        endcase
        result_next = ctl_in.neg ? (~mag + {{(W-1){1'b0}}, 1'b1}) : mag;
    end

    // Strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ===== rtl/integer_divide_modulo_unit_core.sv =====
// Top level of the pipelined 32-bit integer divide/modulo unit.
// Depends on idmu_pkg, idmu_pre, idmu_stage, idmu_post and assert_macros.svh.
//
// Each operation is accepted at a clock edge with start high (busy is always low) and its
// result is transferred, with a one-cycle done strobe, after it has passed the pipeline of
// one conditioning stage, 32 restoring divide stages (one quotient bit each) and one
// result stage. A new operation may start every cycle. The result must
// be taken when done is high; it is not held. op 0 gives the signed quotient (truncated
// toward zero), op 1 the signed remainder (sign of the dividend), op 2 the unsigned
// remainder. A zero divisor or the unused op code gives 0; the most negative value
// divided by -1 gives the most negative value as quotient and 0 as remainder.
`include "assert_macros.svh"

module integer_divide_modulo_unit_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  op,
    input  logic [idmu_pkg::DATA_W-1:0] dividend,
    input  logic [idmu_pkg::DATA_W-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [idmu_pkg::DATA_W-1:0] result
);

    localparam int W = idmu_pkg::DATA_W;

    logic             valid_pipe [0:W];
    idmu_pkg::ctl_t   ctl_pipe   [0:W];
    idmu_pkg::stage_t data_pipe  [0:W];

    // Fully pipelined: a transfer is taken every cycle
    assign busy = 1'b0;

    // Operand conditioning
    idmu_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .dividend  (dividend),
        .divisor   (divisor),
        .valid_reg (valid_pipe[0]),
        .ctl_reg   (ctl_pipe[0]),
        .data_reg  (data_pipe[0])
    );

    // One divide stage per quotient bit
    for (genvar i = 0; i < W; i++)
    begin : g_step
        idmu_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_pipe[i]),
            .ctl_in    (ctl_pipe[i]),
            .data_in   (data_pipe[i]),
            .valid_reg (valid_pipe[i+1]),
            .ctl_reg   (ctl_pipe[i+1]),
            .data_reg  (data_pipe[i+1])
        );
    end

    // Result select and sign restore
    idmu_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (valid_pipe[W]),
        .ctl_in     (ctl_pipe[W]),
        .data_in    (data_pipe[W]),
        .done_reg   (done),
        .result_reg (result)
    );

    // Every accepted transfer comes out after the fixed latency
    `ASSERT_DELAY(a_done_after_lat, clk, rst_n, start && !busy, (idmu_pkg::LAT), done)
    // Zero divisor always yields zero
    `ASSERT_DELAY(a_zero_divisor, clk, rst_n, start && (divisor == '0), (idmu_pkg::LAT), result == '0)
    // The unused op code yields zero
    `ASSERT_DELAY(a_unused_op, clk, rst_n, start && (op == idmu_pkg::OP_UNUSED), (idmu_pkg::LAT), result == '0)

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for integer_divide_modulo_unit_core: signed quotient, signed and
// unsigned remainder, with a directed table then random operands under varying idle rates.
// Depends on idmu_pkg and the RTL of integer_divide_modulo_unit_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W                = idmu_pkg::DATA_W;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 100;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic [1:0]   op;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         busy;
    logic         done;
    logic [W-1:0] result;

    // typed-in answer that rides along with a directed row
    logic         table_check;
    logic [W-1:0] table_value;

    logic [W-1:0] pending_results[$];
    int           errors;
    int           quiet_cycles;

    typedef struct {
        logic [1:0]   op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        bit           known;
        logic [W-1:0] value;
    } div_row_t;

    integer_divide_modulo_unit_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (op),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // two's complement magnitude
    function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // expected quotient or remainder for one operation
    function automatic logic [W-1:0] divmod_result(input logic [1:0] op_v,
                                                   input logic [W-1:0] a,
                                                   input logic [W-1:0] b);
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] q;
        logic [W-1:0] r;
        ma = magnitude(a);
        mb = magnitude(b);
        if (b == '0)
            return '0;
        case (op_v)
            idmu_pkg::OP_SQUOT:
            begin
                q = ma / mb;
                return (a[W-1] ^ b[W-1]) ? (~q + 1'b1) : q;
            end
            idmu_pkg::OP_SREM:
            begin
                r = ma % mb;
                return a[W-1] ? (~r + 1'b1) : r;
            end
            idmu_pkg::OP_UREM:
                return a % b;
            default:
                return '0;
        endcase
    endfunction

    // operand drawn from one of several shapes, so that corners come up often
    function automatic logic [W-1:0] pick_operand();
        logic [W-1:0] v;
        case ($urandom_range(9))
            0:       v = $urandom_range(255);
            1:       v = ~W'($urandom_range(255)) + 1'b1;
            2:       v = W'(1) << $urandom_range(W - 1);
            3:
            begin
                case ($urandom_range(4))
                    0:       v = '0;
                    1:       v = W'(1);
                    2:       v = {1'b0, {(W-1){1'b1}}};
                    3:       v = {1'b1, {(W-1){1'b0}}};
                    default: v = '1;
                endcase
            end
            4, 5:    v = W'($urandom) >> $urandom_range(W - 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // drive one operation and hold it until the transfer completes;
    // each cycle before it is idle with the given chance
    task automatic send_op(input logic [1:0] op_v, input logic [W-1:0] a,
                           input logic [W-1:0] b, input bit known,
                           input logic [W-1:0] value, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start    <= 1'b0;
            op       <= 2'($urandom);
            dividend <= $urandom;
            divisor  <= $urandom;
            @(posedge clk);
        end
        start       <= 1'b1;
        op          <= op_v;
        dividend    <= a;
        divisor     <= b;
        table_check <= known;
        table_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // prediction at each input transfer, check at each done strobe
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                pending_results.push_back(table_check ? table_value
                                                      : divmod_result(op, dividend, divisor));
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, result);
                    errors++;
                end
                else if (pending_results[0] !== result)
                begin
                    $display("%0t: result mismatch, expected %h, got %h",
                             $time, pending_results[0], result);
                    errors++;
                    void'(pending_results.pop_front());
                end
                else
                    void'(pending_results.pop_front());
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        div_row_t rows[$];
        int       idle_rates[4];
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = idmu_pkg::OP_SQUOT;
        dividend     = '0;
        divisor      = '0;
        table_check  = 1'b0;
        table_value  = '0;
        idle_rates   = '{0, 88, 0, 38};

        // directed table: typed answers where obvious, predictor elsewhere
        rows = '{
            // most negative by minus one
            '{idmu_pkg::OP_SQUOT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
            '{idmu_pkg::OP_SREM,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
            '{idmu_pkg::OP_UREM,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
            // zero divisor on every op
            '{idmu_pkg::OP_SQUOT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{idmu_pkg::OP_SREM,  32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{idmu_pkg::OP_UREM,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{idmu_pkg::OP_UNUSED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
            // unused op code
            '{idmu_pkg::OP_UNUSED, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
            '{idmu_pkg::OP_UNUSED, 32'h1234_5678, 32'h0000_0007, 1'b1, 32'h0000_0000},
            // extremes of the operands
            '{idmu_pkg::OP_SQUOT, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF},
            '{idmu_pkg::OP_SQUOT, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000},
            '{idmu_pkg::OP_SQUOT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
            '{idmu_pkg::OP_SQUOT, 32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
            '{idmu_pkg::OP_UREM,  32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
            '{idmu_pkg::OP_UREM,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
            '{idmu_pkg::OP_SREM,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
            // sign handling and truncation toward zero
            '{idmu_pkg::OP_SQUOT, 32'h0000_0007, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFD},
            '{idmu_pkg::OP_SREM,  32'h0000_0007, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001},
            '{idmu_pkg::OP_SREM,  32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFF},
            '{idmu_pkg::OP_SQUOT, 32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, 32'h0},
            '{idmu_pkg::OP_UREM,  32'hFFFF_FFF9, 32'h0000_0002, 1'b0, 32'h0},
            // ordinary values
            '{idmu_pkg::OP_SQUOT, 32'h075B_CD15, 32'h0000_03E8, 1'b0, 32'h0},
            '{idmu_pkg::OP_SREM,  32'hF8A4_32EB, 32'h0000_1F3D, 1'b0, 32'h0},
            '{idmu_pkg::OP_UREM,  32'hDEAD_BEEF, 32'h0001_2345, 1'b0, 32'h0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_op(rows[i].op, rows[i].a, rows[i].b, rows[i].known, rows[i].value, 0);

        // random operands, one phase per sender idle rate
        foreach (idle_rates[p])
        begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                logic [1:0] op_v;
                op_v = ($urandom_range(19) == 0) ? idmu_pkg::OP_UNUSED
                                                 : 2'($urandom_range(2));
                send_op(op_v, pick_operand(), pick_operand(), 1'b0, '0, idle_rates[p]);
            end
        end
        start <= 1'b0;

        // drain the pipeline, then allow for stray strobes
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (idmu_pkg::LAT + 4) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
